@@ rtl/srs_pkg.sv @@
// shared types and constants for the sparse row entry store
// no dependencies; used by the controller, datapath, top level and checker
package srs_pkg;

	localparam int ROWS  = 256;
	localparam int SLOTS = 16;
	localparam int COLS  = 1024;

	localparam int ROW_IN_W = 8;
	localparam int COL_W    = 10;
	localparam int VAL_W    = 32;

	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		MODE_READ   = 2'd0,
		MODE_SET    = 2'd1,
		MODE_ADD    = 2'd2,
		MODE_APPEND = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ADD_ABSENT = 2'd1,
		ST_ROW_FULL   = 2'd2,
		ST_DUP_APPEND = 2'd3
	} status_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [VAL_W-1:0] value;
	} slot_t;

	typedef slot_t [SLOTS-1:0] row_word_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} srs_cmd_t;

endpackage

@@ rtl/srs_ctrl.sv @@
// controller state machine: sequences capture and execute of one beat
// depends on srs_pkg
module srs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output srs_pkg::srs_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign cmd.capture = start && !busy_q;
	assign cmd.execute = (state_q == S_EXEC);

endmodule

@@ rtl/srs_datapath.sv @@
// datapath: row count and slot memories, slot compare, update and result registers
// depends on srs_pkg
module srs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srs_pkg::srs_cmd_t                   cmd,
	input  logic [1:0]                          mode,
	input  logic [srs_pkg::ROW_IN_W-1:0]        row_index,
	input  logic [srs_pkg::COL_W-1:0]           column_index,
	input  logic signed [srs_pkg::VAL_W-1:0]    operand_value,
	output logic signed [srs_pkg::VAL_W-1:0]    entry_value,
	output logic                                found,
	output logic [1:0]                          status
);

	// memories
	srs_pkg::row_word_t             slot_mem [srs_pkg::ROWS];
	logic [srs_pkg::CNT_W-1:0]      cnt_mem  [srs_pkg::ROWS];
	logic [srs_pkg::ROWS-1:0]       cnt_valid_q;

	// first stage: captured item and registered memory reads
	srs_pkg::mode_t                 mode_s1;
	logic [srs_pkg::ROW_IN_W-1:0]   row_s1;
	logic [srs_pkg::COL_W-1:0]      col_s1;
	logic [srs_pkg::VAL_W-1:0]      opv_s1;
	srs_pkg::row_word_t             word_s1;
	logic [srs_pkg::CNT_W-1:0]      cnt_s1;
	logic                           cntv_s1;

	// result registers
	logic [srs_pkg::VAL_W-1:0]      value_q;
	logic                           found_q;
	srs_pkg::status_t               status_q;

	logic [srs_pkg::ROW_AW-1:0]     rd_row;
	logic [srs_pkg::ROW_AW-1:0]     wr_row;
	logic [srs_pkg::CNT_W-1:0]      n_eff;
	logic [srs_pkg::SLOTS-1:0]      hit;
	logic [srs_pkg::SLOT_AW-1:0]    hit_idx;
	logic                           row_ok;
	logic                           col_ok;
	logic                           is_found;
	logic [srs_pkg::VAL_W-1:0]      cur_value;
	logic [srs_pkg::VAL_W-1:0]      new_value;
	srs_pkg::status_t               new_status;
	srs_pkg::row_word_t             new_word;
	logic                           word_we;
	logic                           cnt_we;

	assign rd_row = row_index[srs_pkg::ROW_AW-1:0];
	assign wr_row = row_s1[srs_pkg::ROW_AW-1:0];
	assign row_ok = 32'(row_s1) < 32'(srs_pkg::ROWS);
	assign col_ok = 32'(col_s1) < 32'(srs_pkg::COLS);
	assign n_eff  = cntv_s1 ? cnt_s1 : '0;

	// compare all active slots, first match wins
	always_comb begin
		hit     = '0;
		hit_idx = '0;
		for (int s = 0; s < srs_pkg::SLOTS; s++) begin
			hit[s] = (srs_pkg::CNT_W'(s) < n_eff) && (word_s1[s].column == col_s1) && col_ok;
		end
		for (int s = srs_pkg::SLOTS - 1; s >= 0; s--) begin
			if (hit[s]) begin
				hit_idx = srs_pkg::SLOT_AW'(s);
			end
		end
	end

	assign is_found  = row_ok && (|hit);
	assign cur_value = word_s1[hit_idx].value;

	always_comb begin
		new_value  = '0;
		new_status = srs_pkg::ST_OK;
		new_word   = word_s1;
		word_we    = 1'b0;
		cnt_we     = 1'b0;
		if (row_ok) begin
			case (mode_s1)
				srs_pkg::MODE_READ: begin
					if (is_found) begin
						new_value = cur_value;
					end
				end
				srs_pkg::MODE_SET: begin
					if (is_found) begin
						new_value                = opv_s1;
						new_word[hit_idx].value  = opv_s1;
						word_we                  = 1'b1;
					end
				end
				srs_pkg::MODE_ADD: begin
					if (is_found) begin
						new_value                = cur_value + opv_s1;
						new_word[hit_idx].value  = cur_value + opv_s1;
						word_we                  = 1'b1;
					end else if (opv_s1 != '0) begin
						new_status = srs_pkg::ST_ADD_ABSENT;
					end
				end
				srs_pkg::MODE_APPEND: begin
					if (!col_ok) begin
						new_status = srs_pkg::ST_OK;
					end else if (is_found) begin
						new_value  = cur_value;
						new_status = srs_pkg::ST_DUP_APPEND;
					end else if (32'(n_eff) >= 32'(srs_pkg::SLOTS)) begin
						new_status = srs_pkg::ST_ROW_FULL;
					end else begin
						new_word[n_eff[srs_pkg::SLOT_AW-1:0]].column = col_s1;
						new_word[n_eff[srs_pkg::SLOT_AW-1:0]].value  = '0;
						word_we = 1'b1;
						cnt_we  = 1'b1;
					end
				end
				default: begin
					new_status = srs_pkg::ST_OK;
				end
			endcase
		end
	end

	// capture and memory read, then update and write back
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_s1 <= srs_pkg::mode_t'(mode);
			row_s1  <= row_index;
			col_s1  <= column_index;
			opv_s1  <= operand_value;
			word_s1 <= slot_mem[rd_row];
			cnt_s1  <= cnt_mem[rd_row];
			cntv_s1 <= cnt_valid_q[rd_row];
		end
		if (cmd.execute) begin
			value_q  <= new_value;
			found_q  <= is_found;
			status_q <= new_status;
			if (word_we) begin
				slot_mem[wr_row] <= new_word;
			end
			if (cnt_we) begin
				cnt_mem[wr_row] <= n_eff + 1'b1;
			end
		end
	end

	// per-row valid bits stand in for clearing the count memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_valid_q <= '0;
		end else if (cmd.execute && cnt_we) begin
			cnt_valid_q[wr_row] <= 1'b1;
		end
	end

	assign entry_value = value_q;
	assign found       = found_q;
	assign status      = status_q;

endmodule

@@ rtl/sparse_row_entry_store_top.sv @@
// top level of the sparse row entry store: controller plus datapath
// depends on srs_pkg, srs_ctrl and srs_datapath
//
// A beat is taken at a rising edge where start is high and busy is low. busy
// then stays high until the beat has executed, and the result (entry_value,
// found, status) is shown for exactly one cycle with done high, once the
// captured row and then the result registers have been loaded; start may be
// high again in that same cycle, so a new beat is taken only after the last
// one has executed. First the whole row (all slot columns and values) and its
// active count are read from memory into registers; then every active slot is
// compared at once, the entry is updated and the row is written back. There
// is no way to hold a result off: a receiver must take it in the cycle done is
// high. Row counts start at zero out of reset through per-row valid bits, so
// the block is usable right after reset with no clearing pass.
module sparse_row_entry_store_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       mode,
	input  logic [srs_pkg::ROW_IN_W-1:0]     row_index,
	input  logic [srs_pkg::COL_W-1:0]        column_index,
	input  logic signed [srs_pkg::VAL_W-1:0] operand_value,
	output logic                             done,
	output logic signed [srs_pkg::VAL_W-1:0] entry_value,
	output logic                             found,
	output logic [1:0]                       status
);

	// command path between controller and datapath
	srs_pkg::srs_cmd_t cmd;

	// sequencing: accept, read row, execute, strobe result
	srs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// row memories, parallel slot match, update and result registers
	srs_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.row_index     (row_index),
		.column_index  (column_index),
		.operand_value (operand_value),
		.entry_value   (entry_value),
		.found         (found),
		.status        (status)
	);

endmodule

@@ rtl/srs_checker.sv @@
// port-level checker for the sparse row entry store, bound to the top level
// depends on srs_pkg and sparse_row_entry_store_top
module srs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       found,
	input logic [1:0] status
);

	// an accepted beat always gives its result strobe
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result strobe missing after accepted beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted beat");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on two cycles in a row");

	// an error other than duplicate append means the column was not present
	a_error_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == srs_pkg::ST_ADD_ABSENT || status == srs_pkg::ST_ROW_FULL))
			|-> !found)
		else $error("found set with absent-column status");

endmodule

bind sparse_row_entry_store_top srs_checker u_srs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.found  (found),
	.status (status)
);

@@ dv/srs_entry_checker.sv @@
`timescale 1ns / 1ps
// checker for the sparse row entry store: watches command and result beats,
// keeps its own copy of the row store and compares every result field
// depends on srs_pkg for widths, sizes, mode and status codes
module srs_entry_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [1:0]                       mode,
	input  logic [srs_pkg::ROW_IN_W-1:0]     row_index,
	input  logic [srs_pkg::COL_W-1:0]        column_index,
	input  logic signed [srs_pkg::VAL_W-1:0] operand_value,
	input  logic                             done,
	input  logic signed [srs_pkg::VAL_W-1:0] entry_value,
	input  logic                             found,
	input  logic [1:0]                       status,
	input  logic                             end_check,
	output int                               fail_count,
	output int                               pending,
	output int                               results_seen,
	output int                               full_seen,
	output int                               dup_seen,
	output int                               absent_add_seen
);

	typedef struct packed {
		logic [srs_pkg::VAL_W-1:0] value;
		logic                      hit;
		srs_pkg::status_t          st;
	} entry_result_t;

	// shadow of the row store
	logic [srs_pkg::CNT_W-1:0] row_fill [srs_pkg::ROWS];
	logic [srs_pkg::COL_W-1:0] slot_col [srs_pkg::ROWS][srs_pkg::SLOTS];
	logic [srs_pkg::VAL_W-1:0] slot_val [srs_pkg::ROWS][srs_pkg::SLOTS];

	entry_result_t pending_entries [$];
	logic          leftovers_checked;

	task automatic report_mismatch(input string msg);
		$display("[%0t] checker: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic entry_result_t lookup_entry(input srs_pkg::mode_t op,
			input logic [srs_pkg::ROW_IN_W-1:0] r, input logic [srs_pkg::COL_W-1:0] c,
			input logic [srs_pkg::VAL_W-1:0] amt);
		entry_result_t res;
		int            hit_slot;
		int            fill;
		res = '{value: '0, hit: 1'b0, st: srs_pkg::ST_OK};
		hit_slot = -1;
		if (int'(r) >= srs_pkg::ROWS)
			return res;
		fill = int'(row_fill[r]);
		// first matching active slot wins
		if (int'(c) < srs_pkg::COLS)
			for (int s = 0; s < srs_pkg::SLOTS; s++)
				if (hit_slot < 0 && s < fill && slot_col[r][s] == c)
					hit_slot = s;
		res.hit = (hit_slot >= 0);
		case (op)
			srs_pkg::MODE_READ: begin
				if (res.hit)
					res.value = slot_val[r][hit_slot];
			end
			srs_pkg::MODE_SET: begin
				if (res.hit) begin
					slot_val[r][hit_slot] = amt;
					res.value = amt;
				end
			end
			srs_pkg::MODE_ADD: begin
				if (res.hit) begin
					slot_val[r][hit_slot] = slot_val[r][hit_slot] + amt;
					res.value = slot_val[r][hit_slot];
				end else if (amt != '0) begin
					res.st = srs_pkg::ST_ADD_ABSENT;
				end
			end
			default: begin
				if (int'(c) >= srs_pkg::COLS) begin
					// out of range append does nothing
				end else if (res.hit) begin
					res.value = slot_val[r][hit_slot];
					res.st = srs_pkg::ST_DUP_APPEND;
				end else if (fill >= srs_pkg::SLOTS) begin
					res.st = srs_pkg::ST_ROW_FULL;
				end else begin
					slot_col[r][fill] = c;
					slot_val[r][fill] = '0;
					row_fill[r] = srs_pkg::CNT_W'(fill + 1);
				end
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		entry_result_t want;
		if (!arst_n) begin
			pending_entries.delete();
			for (int r = 0; r < srs_pkg::ROWS; r++)
				row_fill[r] = '0;
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			full_seen = 0;
			dup_seen = 0;
			absent_add_seen = 0;
			leftovers_checked = 1'b0;
		end else begin
			// results first, then the new command
			if (done) begin
				results_seen++;
				if (pending_entries.size() == 0) begin
					report_mismatch("result beat with nothing outstanding");
				end else begin
					want = pending_entries.pop_front();
					if (entry_value !== want.value)
						report_mismatch($sformatf("entry_value %h, want %h",
							entry_value, want.value));
					if (found !== want.hit)
						report_mismatch($sformatf("found %b, want %b", found, want.hit));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, want %0d", status, want.st));
					if (want.st == srs_pkg::ST_ROW_FULL)
						full_seen++;
					if (want.st == srs_pkg::ST_DUP_APPEND)
						dup_seen++;
					if (want.st == srs_pkg::ST_ADD_ABSENT)
						absent_add_seen++;
				end
			end
			if (start && !busy)
				pending_entries.push_back(lookup_entry(srs_pkg::mode_t'(mode), row_index,
					column_index, operand_value));
			if (end_check && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (pending_entries.size() != 0)
					report_mismatch($sformatf("%0d results never arrived",
						pending_entries.size()));
			end
			pending = pending_entries.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// top of the sparse row entry store testbench: clock, reset, command stimulus
// and verdict; depends on srs_pkg, sparse_row_entry_store_top and srs_entry_checker
module testbench;

	localparam int RANDOM_ITEMS = 1700;
	localparam int STALL_LIMIT  = 1000;
	localparam int IDLE_PCT     = 37;

	logic                             clk;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic [1:0]                       mode = srs_pkg::MODE_READ;
	logic [srs_pkg::ROW_IN_W-1:0]     row_index = '0;
	logic [srs_pkg::COL_W-1:0]        column_index = '0;
	logic signed [srs_pkg::VAL_W-1:0] operand_value = '0;
	logic                             end_check = 1'b0;

	logic                             busy;
	logic                             done;
	logic signed [srs_pkg::VAL_W-1:0] entry_value;
	logic                             found;
	logic [1:0]                       status;

	int fail_count;
	int pending;
	int results_seen;
	int full_seen;
	int dup_seen;
	int absent_add_seen;

	// stimulus knobs and bookkeeping
	int idle_pct = IDLE_PCT;
	int mode_count [4];
	int stall_cycles = 0;

	sparse_row_entry_store_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.row_index     (row_index),
		.column_index  (column_index),
		.operand_value (operand_value),
		.done          (done),
		.entry_value   (entry_value),
		.found         (found),
		.status        (status)
	);

	srs_entry_checker entry_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.row_index       (row_index),
		.column_index    (column_index),
		.operand_value   (operand_value),
		.done            (done),
		.entry_value     (entry_value),
		.found           (found),
		.status          (status),
		.end_check       (end_check),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_seen    (results_seen),
		.full_seen       (full_seen),
		.dup_seen        (dup_seen),
		.absent_add_seen (absent_add_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: ends the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles", $realtime, stall_cycles);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// one command beat; called at a rising edge, returns at the accepting edge
	task automatic issue_command(input srs_pkg::mode_t op,
			input logic [srs_pkg::ROW_IN_W-1:0] r,
			input logic [srs_pkg::COL_W-1:0] c, input logic [srs_pkg::VAL_W-1:0] amt);
		// random idle cycles ahead of the beat, start held low
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		mode          <= op;
		row_index     <= r;
		column_index  <= c;
		operand_value <= amt;
		// busy seen here is the value before the edge, so busy low means taken
		do
			@(posedge clk);
		while (busy);
		mode_count[op]++;
	endtask

	// hold off the sender until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		logic [srs_pkg::ROW_IN_W-1:0] hot_rows [6];
		logic [srs_pkg::COL_W-1:0]    col_pool [24];
		logic [srs_pkg::ROW_IN_W-1:0] r;
		logic [srs_pkg::COL_W-1:0]    c;
		logic [srs_pkg::VAL_W-1:0]    amt;
		srs_pkg::mode_t               op;
		int                           pick;

		foreach (mode_count[k])
			mode_count[k] = 0;

		// a few hot rows so that rows fill up, plus a shared column pool
		// large enough to overflow a row and to hit duplicates often
		hot_rows[0] = '0;
		hot_rows[1] = '1;
		for (int k = 2; k < 6; k++)
			hot_rows[k] = srs_pkg::ROW_IN_W'($urandom_range(255));
		col_pool[0] = '0;
		col_pool[1] = '1;
		for (int k = 2; k < 24; k++)
			col_pool[k] = srs_pkg::COL_W'($urandom_range(1023));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, absent set and add, append, duplicate,
		// wraparound at both ends, corner rows and columns
		issue_command(srs_pkg::MODE_READ,   8'd0,   10'd0,    32'd0);
		issue_command(srs_pkg::MODE_SET,    8'd0,   10'd0,    32'd5);
		issue_command(srs_pkg::MODE_ADD,    8'd0,   10'd0,    32'd7);
		issue_command(srs_pkg::MODE_ADD,    8'd0,   10'd0,    32'd0);
		issue_command(srs_pkg::MODE_APPEND, 8'd0,   10'd0,    32'hdead_beef);
		issue_command(srs_pkg::MODE_APPEND, 8'd0,   10'd0,    32'd0);
		issue_command(srs_pkg::MODE_SET,    8'd0,   10'd0,    32'h7fff_ffff);
		issue_command(srs_pkg::MODE_ADD,    8'd0,   10'd0,    32'd1);
		issue_command(srs_pkg::MODE_READ,   8'd0,   10'd0,    32'd0);
		issue_command(srs_pkg::MODE_APPEND, 8'd0,   10'd1023, 32'd0);
		issue_command(srs_pkg::MODE_SET,    8'd0,   10'd1023, 32'h8000_0000);
		issue_command(srs_pkg::MODE_ADD,    8'd0,   10'd1023, 32'hffff_ffff);
		issue_command(srs_pkg::MODE_APPEND, 8'd0,   10'd1023, 32'd0);
		issue_command(srs_pkg::MODE_APPEND, 8'd255, 10'd1023, 32'd0);
		issue_command(srs_pkg::MODE_ADD,    8'd255, 10'd1023, 32'd0);
		issue_command(srs_pkg::MODE_SET,    8'd255, 10'd1023, 32'hffff_ffff);
		issue_command(srs_pkg::MODE_READ,   8'd255, 10'd1023, 32'd0);
		issue_command(srs_pkg::MODE_READ,   8'd255, 10'd0,    32'd0);
		issue_command(srs_pkg::MODE_APPEND, 8'd255, 10'd682,  32'd0);
		issue_command(srs_pkg::MODE_SET,    8'd255, 10'd341,  32'h5555_5555);
		issue_command(srs_pkg::MODE_APPEND, 8'd170, 10'd341,  32'd0);
		issue_command(srs_pkg::MODE_ADD,    8'd170, 10'd341,  32'h5555_5555);
		issue_command(srs_pkg::MODE_READ,   8'd170, 10'd341,  32'd0);
		issue_command(srs_pkg::MODE_SET,    8'd85,  10'd0,    32'haaaa_aaaa);

		drain_results();

		// random part: mostly hot rows and pooled columns, some fully random
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// a long stretch with the sender never idling
			idle_pct = (n >= 700 && n < 1000) ? 0 : IDLE_PCT;
			if (n == 400 || n == 1200)
				drain_results();

			pick = $urandom_range(99);
			if (pick < 25)
				op = srs_pkg::MODE_READ;
			else if (pick < 45)
				op = srs_pkg::MODE_SET;
			else if (pick < 75)
				op = srs_pkg::MODE_ADD;
			else
				op = srs_pkg::MODE_APPEND;

			if ($urandom_range(99) < 80)
				r = hot_rows[$urandom_range(5)];
			else
				r = srs_pkg::ROW_IN_W'($urandom_range(255));
			if ($urandom_range(99) < 85)
				c = col_pool[$urandom_range(23)];
			else
				c = srs_pkg::COL_W'($urandom_range(1023));

			// operand mix: full range, zero, boundary values, small deltas
			pick = $urandom_range(99);
			if (pick < 40)
				amt = $urandom();
			else if (pick < 55)
				amt = '0;
			else if (pick < 70) begin
				case ($urandom_range(3))
					0: amt = 32'h7fff_ffff;
					1: amt = 32'h8000_0000;
					2: amt = 32'hffff_ffff;
					default: amt = 32'd1;
				endcase
			end else
				amt = $urandom_range(16) - 8;

			issue_command(op, r, c, amt);
		end

		// wait for the tail, then for any stray result beat
		drain_results();
		repeat (4) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);

		$display("testbench: %0d reads, %0d sets, %0d adds, %0d appends, %0d results",
			mode_count[srs_pkg::MODE_READ], mode_count[srs_pkg::MODE_SET],
			mode_count[srs_pkg::MODE_ADD], mode_count[srs_pkg::MODE_APPEND],
			results_seen);
		$display("testbench: %0d full-row appends, %0d duplicate appends, %0d absent adds",
			full_seen, dup_seen, absent_add_seen);
		if (fail_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
